### design/rtlp_pkg.sv
// Shared types, constants and saturating arithmetic for the lens projection pipeline.
package rtlp_pkg;

    localparam int COORD_FRAC_BITS = 16;

    localparam int WIDE_W = 64;
    localparam int WIDE_FRAC = 32;

    localparam int DIV_STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES = WIDE_W / DIV_STEPS_PER_STAGE;
    localparam int DIV_LAT = DIV_STAGES + 2;
    localparam int MUL_LAT = 5;

    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    localparam logic [2:0] REG_FOCAL_X = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y = 3'd1;
    localparam logic [2:0] REG_PRINCIPAL = 3'd2;
    localparam logic [2:0] REG_K1 = 3'd3;
    localparam logic [2:0] REG_K2 = 3'd4;
    localparam logic [2:0] REG_K3 = 3'd5;
    localparam logic [2:0] REG_P1 = 3'd6;
    localparam logic [2:0] REG_P2 = 3'd7;

    localparam logic [31:0] FOCAL_RESET = 32'h0001_0000;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic ov;
        logic signed [63:0] val;
    } t_sval;

    localparam int SVAL_W = $bits(t_sval);

    function automatic logic [63:0] mag64(logic signed [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic t_sval from_mag(logic neg, logic [63:0] m);
        t_sval r;
        r.ov = 1'b0;
        if (neg) begin
            if (m[63]) begin
                r.val = S64_MIN;
                r.ov = |m[62:0];
            end else begin
                r.val = 64'd0 - m;
            end
        end else begin
            if (m[63]) begin
                r.val = S64_MAX;
                r.ov = 1'b1;
            end else begin
                r.val = m;
            end
        end
        return r;
    endfunction

    function automatic t_sval sadd(t_sval a, t_sval b);
        logic signed [64:0] s;
        t_sval r;
        s = {a.val[63], a.val} + {b.val[63], b.val};
        r.ov = a.ov | b.ov;
        if (s[64] != s[63]) begin
            r.ov = 1'b1;
            r.val = s[64] ? S64_MIN : S64_MAX;
        end else begin
            r.val = s[63:0];
        end
        return r;
    endfunction

endpackage

### design/rtlp_point_if.sv
// Input channel: one camera-space point per word.
interface rtlp_point_if;
    logic valid;
    logic ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z, input ready);
    modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

### design/rtlp_pixel_if.sv
// Output channel: one projected pixel per word.
interface rtlp_pixel_if;
    logic valid;
    logic ready;
    logic signed [31:0] pixel_x;
    logic signed [31:0] pixel_y;
    logic behind_camera;
    logic overflowed;

    modport source (output valid, output pixel_x, output pixel_y, output behind_camera,
                    output overflowed, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input behind_camera,
                  input overflowed, output ready);
endinterface

### design/radial_tangential_lens_projection.sv
// Top level: radial and tangential lens distortion projection pipeline.
// Projects camera-space points (signed fixed point) to distorted pixel coordinates.
// i_point carries one point word (x, y, z); o_pixel carries one pixel word
// (pixel_x, pixel_y, behind_camera, overflowed). Both use valid/ready; a word moves
// at a rising edge with valid and ready high.
// Focal lengths, principal point and the k1..k3, p1, p2 coefficients sit in an
// APB-style register file, 64-bit data, register i at byte address 8*i; write them
// while no point is in flight.
// Throughput: one point per clock unless the receiver stalls o_pixel. The path from the
// accepting edge to o_pixel.valid runs through the 16-stage radix-16 divider for x/z
// and y/z followed by the chain of six dependent 5-stage multiplies and their adds.
// Reset clears all valid bits and loads the register reset values.
// When the receiver holds ready low with a result waiting, the whole pipe holds
// and i_point.ready drops; nothing is lost or repeated. Bubbles travel as empty
// stages.
module radial_tangential_lens_projection #(
    parameter int COORD_FRAC_BITS = rtlp_pkg::COORD_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    rtlp_point_if.sink                         i_point,
    rtlp_pixel_if.source                       o_pixel,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rtlp_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [rtlp_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rtlp_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    localparam int M = rtlp_pkg::MUL_LAT;
    localparam int D = rtlp_pkg::DIV_LAT;
    localparam int LAT = D + 6 * M + 6;
    localparam int SH = rtlp_pkg::WIDE_FRAC - COORD_FRAC_BITS;
    localparam logic [31:0] BEHIND_PIX = ~((32'd1 << COORD_FRAC_BITS) - 32'd1);
    localparam rtlp_pkg::t_sval ONE = {1'b0, 64'sh1_0000_0000};

    logic [31:0] r_fx, r_fy, r_k1, r_k2, r_k3, r_p1, r_p2;
    logic [47:0] r_pp;
    logic [2:0]  cfg_idx;
    logic        en;
    logic [LAT-1:0] r_valid;

    assign cfg_idx = paddr[5:3];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= rtlp_pkg::FOCAL_RESET;
            r_fy <= rtlp_pkg::FOCAL_RESET;
            r_pp <= '0;
            r_k1 <= '0;
            r_k2 <= '0;
            r_k3 <= '0;
            r_p1 <= '0;
            r_p2 <= '0;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                rtlp_pkg::REG_FOCAL_X:   r_fx <= pwdata[31:0];
                rtlp_pkg::REG_FOCAL_Y:   r_fy <= pwdata[31:0];
                rtlp_pkg::REG_PRINCIPAL: r_pp <= pwdata[47:0];
                rtlp_pkg::REG_K1:        r_k1 <= pwdata[31:0];
                rtlp_pkg::REG_K2:        r_k2 <= pwdata[31:0];
                rtlp_pkg::REG_K3:        r_k3 <= pwdata[31:0];
                rtlp_pkg::REG_P1:        r_p1 <= pwdata[31:0];
                rtlp_pkg::REG_P2:        r_p2 <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            rtlp_pkg::REG_FOCAL_X:   prdata = {32'd0, r_fx};
            rtlp_pkg::REG_FOCAL_Y:   prdata = {32'd0, r_fy};
            rtlp_pkg::REG_PRINCIPAL: prdata = {16'd0, r_pp};
            rtlp_pkg::REG_K1:        prdata = {32'd0, r_k1};
            rtlp_pkg::REG_K2:        prdata = {32'd0, r_k2};
            rtlp_pkg::REG_K3:        prdata = {32'd0, r_k3};
            rtlp_pkg::REG_P1:        prdata = {32'd0, r_p1};
            rtlp_pkg::REG_P2:        prdata = {32'd0, r_p2};
            default:                 prdata = '0;
        endcase
    end

    rtlp_pkg::t_sval k1_s, k2_s, k3_s, p1_s, p2_s, fx_s, fy_s, cx_s, cy_s;
    assign k1_s = {1'b0, {{28{r_k1[31]}}, r_k1, 4'd0}};
    assign k2_s = {1'b0, {{28{r_k2[31]}}, r_k2, 4'd0}};
    assign k3_s = {1'b0, {{28{r_k3[31]}}, r_k3, 4'd0}};
    assign p1_s = {1'b0, {{28{r_p1[31]}}, r_p1, 4'd0}};
    assign p2_s = {1'b0, {{28{r_p2[31]}}, r_p2, 4'd0}};
    assign fx_s = {1'b0, {16'd0, r_fx, 16'd0}};
    assign fy_s = {1'b0, {16'd0, r_fy, 16'd0}};
    assign cx_s = {1'b0, {16'd0, r_pp[47:24], 24'd0}};
    assign cy_s = {1'b0, {16'd0, r_pp[23:0], 24'd0}};

    // hold every stage while a result waits
    assign en = ~r_valid[LAT-1] | o_pixel.ready;
    assign i_point.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[LAT-2:0], i_point.valid};
        end
    end

    rtlp_pkg::t_sval qx, qy, x_d, y_d;
    rtlp_pkg::t_sval x2, y2, xy;
    rtlp_pkg::t_sval r_r2, r_xy2, r_ax, r_ay, r_sx, r_sy;
    rtlp_pkg::t_sval r4, k1r2, xyp1, xyp2, p2sx, p1sy, r2_d;
    rtlp_pkg::t_sval r6, k2r4, k3r6, r_rad1, rad1_d, r_rad2, rad2_d, r_rad;
    rtlp_pkg::t_sval xrad, yrad, xyp1_d, xyp2_d, p2sx_d, p1sy_d;
    rtlp_pkg::t_sval r_x1a, r_y1a, r_x1, r_y1, fxx1, fyy1, r_u, r_v;
    logic behind_d;

    rtlp_div u_div_x (.i_clk, .i_en(en), .i_num(i_point.point_x),
                      .i_den(i_point.point_z), .o_q(qx));
    rtlp_div u_div_y (.i_clk, .i_en(en), .i_num(i_point.point_y),
                      .i_den(i_point.point_z), .o_q(qy));

    rtlp_mul u_mul_x2 (.i_clk, .i_en(en), .i_a(qx), .i_b(qx), .o_p(x2));
    rtlp_mul u_mul_y2 (.i_clk, .i_en(en), .i_a(qy), .i_b(qy), .o_p(y2));
    rtlp_mul u_mul_xy (.i_clk, .i_en(en), .i_a(qx), .i_b(qy), .o_p(xy));

    rtlp_mul u_mul_r4   (.i_clk, .i_en(en), .i_a(r_r2), .i_b(r_r2), .o_p(r4));
    rtlp_mul u_mul_k1   (.i_clk, .i_en(en), .i_a(k1_s), .i_b(r_r2), .o_p(k1r2));
    rtlp_mul u_mul_xyp1 (.i_clk, .i_en(en), .i_a(r_xy2), .i_b(p1_s), .o_p(xyp1));
    rtlp_mul u_mul_xyp2 (.i_clk, .i_en(en), .i_a(r_xy2), .i_b(p2_s), .o_p(xyp2));
    rtlp_mul u_mul_p2sx (.i_clk, .i_en(en), .i_a(p2_s), .i_b(r_sx), .o_p(p2sx));
    rtlp_mul u_mul_p1sy (.i_clk, .i_en(en), .i_a(p1_s), .i_b(r_sy), .o_p(p1sy));

    rtlp_delay #(.N(M)) u_dly_r2 (.i_clk, .i_en(en), .i_d(r_r2), .o_q(r2_d));
    rtlp_mul u_mul_r6 (.i_clk, .i_en(en), .i_a(r2_d), .i_b(r4), .o_p(r6));
    rtlp_mul u_mul_k2 (.i_clk, .i_en(en), .i_a(k2_s), .i_b(r4), .o_p(k2r4));
    rtlp_mul u_mul_k3 (.i_clk, .i_en(en), .i_a(k3_s), .i_b(r6), .o_p(k3r6));

    rtlp_delay #(.N(M-1)) u_dly_rad1 (.i_clk, .i_en(en), .i_d(r_rad1), .o_q(rad1_d));
    rtlp_delay #(.N(M-1)) u_dly_rad2 (.i_clk, .i_en(en), .i_d(r_rad2), .o_q(rad2_d));

    rtlp_delay #(.N(4*M+2)) u_dly_x (.i_clk, .i_en(en), .i_d(qx), .o_q(x_d));
    rtlp_delay #(.N(4*M+2)) u_dly_y (.i_clk, .i_en(en), .i_d(qy), .o_q(y_d));
    rtlp_mul u_mul_xrad (.i_clk, .i_en(en), .i_a(x_d), .i_b(r_rad), .o_p(xrad));
    rtlp_mul u_mul_yrad (.i_clk, .i_en(en), .i_a(y_d), .i_b(r_rad), .o_p(yrad));

    rtlp_delay #(.N(3*M+1)) u_dly_xyp1 (.i_clk, .i_en(en), .i_d(xyp1), .o_q(xyp1_d));
    rtlp_delay #(.N(3*M+1)) u_dly_xyp2 (.i_clk, .i_en(en), .i_d(xyp2), .o_q(xyp2_d));
    rtlp_delay #(.N(3*M+1)) u_dly_p2sx (.i_clk, .i_en(en), .i_d(p2sx), .o_q(p2sx_d));
    rtlp_delay #(.N(3*M+1)) u_dly_p1sy (.i_clk, .i_en(en), .i_d(p1sy), .o_q(p1sy_d));

    rtlp_mul u_mul_fx (.i_clk, .i_en(en), .i_a(fx_s), .i_b(r_x1), .o_p(fxx1));
    rtlp_mul u_mul_fy (.i_clk, .i_en(en), .i_a(fy_s), .i_b(r_y1), .o_p(fyy1));

    rtlp_delay #(.W(1), .N(LAT-1)) u_dly_behind (
        .i_clk, .i_en(en), .i_d(i_point.point_z <= 32'sd0), .o_q(behind_d));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r2 <= rtlp_pkg::sadd(x2, y2);
            r_xy2 <= rtlp_pkg::sadd(xy, xy);
            r_ax <= rtlp_pkg::sadd(x2, x2);
            r_ay <= rtlp_pkg::sadd(y2, y2);
            r_sx <= rtlp_pkg::sadd(r_r2, r_ax);
            r_sy <= rtlp_pkg::sadd(r_r2, r_ay);
            r_rad1 <= rtlp_pkg::sadd(ONE, k1r2);
            r_rad2 <= rtlp_pkg::sadd(rad1_d, k2r4);
            r_rad <= rtlp_pkg::sadd(rad2_d, k3r6);
            r_x1a <= rtlp_pkg::sadd(xrad, xyp1_d);
            r_y1a <= rtlp_pkg::sadd(yrad, xyp2_d);
            r_x1 <= rtlp_pkg::sadd(r_x1a, p2sx_d);
            r_y1 <= rtlp_pkg::sadd(r_y1a, p1sy_d);
            r_u <= rtlp_pkg::sadd(cx_s, fxx1);
            r_v <= rtlp_pkg::sadd(cy_s, fyy1);
        end
    end

    logic [63:0] mu, mv;
    logic [31:0] n_px, n_py;
    logic        ovx, ovy;

    always_comb begin
        mu = rtlp_pkg::mag64(r_u.val) >> SH;
        mv = rtlp_pkg::mag64(r_v.val) >> SH;
        ovx = 1'b0;
        ovy = 1'b0;
        if (r_u.val[63]) begin
            if (mu > 64'h8000_0000) begin
                ovx = 1'b1;
                mu = 64'h8000_0000;
            end
            n_px = 32'd0 - mu[31:0];
        end else begin
            if (mu > 64'h7FFF_FFFF) begin
                ovx = 1'b1;
                mu = 64'h7FFF_FFFF;
            end
            n_px = mu[31:0];
        end
        if (r_v.val[63]) begin
            if (mv > 64'h8000_0000) begin
                ovy = 1'b1;
                mv = 64'h8000_0000;
            end
            n_py = 32'd0 - mv[31:0];
        end else begin
            if (mv > 64'h7FFF_FFFF) begin
                ovy = 1'b1;
                mv = 64'h7FFF_FFFF;
            end
            n_py = mv[31:0];
        end
    end

    logic signed [31:0] r_pix_x, r_pix_y;
    logic r_behind, r_ovf;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_behind <= behind_d;
            if (behind_d) begin
                r_pix_x <= BEHIND_PIX;
                r_pix_y <= BEHIND_PIX;
                r_ovf <= 1'b0;
            end else begin
                r_pix_x <= n_px;
                r_pix_y <= n_py;
                r_ovf <= r_u.ov | r_v.ov | ovx | ovy;
            end
        end
    end

    assign o_pixel.valid = r_valid[LAT-1];
    assign o_pixel.pixel_x = r_pix_x;
    assign o_pixel.pixel_y = r_pix_y;
    assign o_pixel.behind_camera = r_behind;
    assign o_pixel.overflowed = r_ovf;
endmodule

### design/rtlp_delay.sv
// Stallable delay line for aligning operands between pipeline branches.
module rtlp_delay #(
    parameter int W = rtlp_pkg::SVAL_W,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_sh [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int i = 1; i < N; i++) begin
                r_sh[i] <= r_sh[i-1];
            end
        end
    end

    assign o_q = r_sh[N-1];
endmodule

### design/rtlp_div.sv
// Pipelined restoring divider: (|num| << 32) / den as saturated Q31.32.
module rtlp_div (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [31:0]   i_num,
    input  logic [31:0]          i_den,
    output rtlp_pkg::t_sval      o_q
);
    localparam int STAGES = rtlp_pkg::DIV_STAGES;
    localparam int STEPS = rtlp_pkg::DIV_STEPS_PER_STAGE;

    logic [31:0] r_rem [STAGES+1];
    logic [63:0] r_w   [STAGES+1];
    logic [31:0] r_d   [STAGES+1];
    logic        r_neg [STAGES+1];
    logic [31:0] n_rem [1:STAGES];
    logic [63:0] n_w   [1:STAGES];
    rtlp_pkg::t_sval r_q;

    always_comb begin
        logic [32:0] sh;
        logic [33:0] tr;
        logic [31:0] rem;
        logic [63:0] w;
        for (int s = 1; s <= STAGES; s++) begin
            rem = r_rem[s-1];
            w = r_w[s-1];
            for (int j = 0; j < STEPS; j++) begin
                sh = {rem, w[63]};
                tr = {1'b0, sh} - {2'b00, r_d[s-1]};
                if (!tr[33]) begin
                    rem = tr[31:0];
                    w = {w[62:0], 1'b1};
                end else begin
                    rem = sh[31:0];
                    w = {w[62:0], 1'b0};
                end
            end
            n_rem[s] = rem;
            n_w[s] = w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_w[0] <= {(i_num[31] ? (32'd0 - i_num) : i_num), 32'd0};
            r_d[0] <= i_den;
            r_neg[0] <= i_num[31];
            for (int s = 1; s <= STAGES; s++) begin
                r_rem[s] <= n_rem[s];
                r_w[s] <= n_w[s];
                r_d[s] <= r_d[s-1];
                r_neg[s] <= r_neg[s-1];
            end
            r_q <= rtlp_pkg::from_mag(r_neg[STAGES], r_w[STAGES]);
        end
    end

    assign o_q = r_q;
endmodule

### design/rtlp_mul.sv
// Pipelined saturating Q31.32 multiplier built from four 32x32 partial products.
module rtlp_mul (
    input  logic            i_clk,
    input  logic            i_en,
    input  rtlp_pkg::t_sval i_a,
    input  rtlp_pkg::t_sval i_b,
    output rtlp_pkg::t_sval o_p
);
    logic [63:0] r_ma, r_mb;
    logic [63:0] r_p00, r_p01, r_p10, r_p11;
    logic [33:0] r_mid;
    logic [63:0] r_hi;
    logic [63:0] r_m;
    logic        r_hov;
    logic [3:0]  r_neg, r_ov;
    logic [63:0] n_hi;
    rtlp_pkg::t_sval n_fm, r_p;

    assign n_hi = r_hi + {62'd0, r_mid[33:32]};
    assign n_fm = rtlp_pkg::from_mag(r_neg[3], r_m);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma <= rtlp_pkg::mag64(i_a.val);
            r_mb <= rtlp_pkg::mag64(i_b.val);
            r_neg[0] <= i_a.val[63] ^ i_b.val[63];
            r_ov[0] <= i_a.ov | i_b.ov;

            r_p00 <= r_ma[31:0] * r_mb[31:0];
            r_p01 <= r_ma[31:0] * r_mb[63:32];
            r_p10 <= r_ma[63:32] * r_mb[31:0];
            r_p11 <= r_ma[63:32] * r_mb[63:32];
            r_neg[1] <= r_neg[0];
            r_ov[1] <= r_ov[0];

            r_mid <= {2'b00, r_p00[63:32]} + {2'b00, r_p01[31:0]} + {2'b00, r_p10[31:0]};
            r_hi <= r_p11 + {32'd0, r_p01[63:32]} + {32'd0, r_p10[63:32]};
            r_neg[2] <= r_neg[1];
            r_ov[2] <= r_ov[1];

            r_m <= {n_hi[31:0], r_mid[31:0]};
            r_hov <= |n_hi[63:32];
            r_neg[3] <= r_neg[2];
            r_ov[3] <= r_ov[2];

            if (r_hov) begin
                r_p.ov <= 1'b1;
                r_p.val <= r_neg[3] ? rtlp_pkg::S64_MIN : rtlp_pkg::S64_MAX;
            end else begin
                r_p.ov <= r_ov[3] | n_fm.ov;
                r_p.val <= n_fm.val;
            end
        end
    end

    assign o_p = r_p;
endmodule
